### rtl/core/c_syntax_highlight_lexer_macros.svh
// -----------------------------------------------------------------------------
// C syntax highlight lexer assertion macros
// Shared concurrent assertion forms used by the block.
// -----------------------------------------------------------------------------
`ifndef C_SYNTAX_HIGHLIGHT_LEXER_MACROS_SVH
`define C_SYNTAX_HIGHLIGHT_LEXER_MACROS_SVH

// same-cycle implication, disabled during reset
`define CSHL_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, active during reset as well
`define CSHL_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/core/cshl_pkg.sv
// -----------------------------------------------------------------------------
// C syntax highlight lexer package
// Shared types, character codes and escape sequence tables.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cshl_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_ESC    = 8'h1B;
   localparam logic [7:0] CH_LBRK   = 8'h5B;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;

   typedef enum logic [2:0] {
      ESC_NONE   = 3'd0,
      ESC_BLOCK  = 3'd1,
      ESC_INLINE = 3'd2,
      ESC_STRING = 3'd3,
      ESC_IDENT  = 3'd4,
      ESC_OFF    = 3'd5
   } esc_type;

   // one queued item: the result bytes it produces, in segment order
   typedef struct packed {
      esc_type    pre;
      logic       lead;
      esc_type    mid;
      logic       has_byte;
      logic [7:0] data;
      logic       err;
      logic       post;
      logic       trail;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [2:0] esc_len(input esc_type kind);
      logic [2:0] len;
      unique case (kind)
         ESC_BLOCK:  len = 3'd4;
         ESC_INLINE: len = 3'd5;
         ESC_STRING: len = 3'd7;
         ESC_IDENT:  len = 3'd7;
         ESC_OFF:    len = 3'd3;
         default:    len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] esc_byte(input esc_type kind, input logic [2:0] pos);
      logic [7:0] b;
      b = 8'h00;
      if (pos == 3'd0) begin
         b = CH_ESC;
      end else if (pos == 3'd1) begin
         b = CH_LBRK;
      end else begin
         unique case (kind)
            ESC_BLOCK: begin
               b = (pos == 3'd2) ? 8'h36 : 8'h6D;
            end
            ESC_INLINE: begin
               unique case (pos)
                  3'd2:    b = 8'h33;
                  3'd3:    b = 8'h30;
                  default: b = 8'h6D;
               endcase
            end
            ESC_STRING, ESC_IDENT: begin
               unique case (pos)
                  3'd2:    b = 8'h31;
                  3'd3:    b = 8'h3B;
                  3'd4:    b = 8'h33;
                  3'd5:    b = (kind == ESC_STRING) ? 8'h33 : 8'h34;
                  default: b = 8'h6D;
               endcase
            end
            default: begin
               b = 8'h6D;
            end
         endcase
      end
      return b;
   endfunction

endpackage

`default_nettype wire

### rtl/core/cshl_ifs.sv
// -----------------------------------------------------------------------------
// C syntax highlight lexer channel interfaces
// Valid/ready channels for text bytes in and highlighted bytes out.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cshl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface cshl_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       parse_error;
   logic       last_of_run;

   modport source (output valid, output out_byte, output parse_error, output last_of_run,
                   input ready);
   modport sink   (input valid, input out_byte, input parse_error, input last_of_run,
                   output ready);
endinterface

`default_nettype wire

### rtl/core/cshl_front.sv
// -----------------------------------------------------------------------------
// C syntax highlight lexer front end
// Accepts text bytes, tracks the lexical mode and queues an output plan.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cshl_front
   import cshl_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   cshl_req_if.sink    req_chan,
   input  q_status_type q_status,
   output logic        push,
   output cmd_type     push_cmd
);

   typedef enum logic [2:0] {
      MODE_GLOBAL     = 3'd0,
      MODE_SLASH      = 3'd1,
      MODE_IDENT      = 3'd2,
      MODE_BLOCK      = 3'd3,
      MODE_BLOCK_STAR = 3'd4,
      MODE_INLINE     = 3'd5,
      MODE_STRING     = 3'd6,
      MODE_STRING_ESC = 3'd7
   } mode_type;

   typedef struct packed {
      esc_type  mid;
      logic     has_byte;
      logic     err;
      mode_type mode;
   } glob_type;

   mode_type mode_ff, mode_in;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_plain(input logic [7:0] c);
      return c == 8'h20 || c == CH_LF || c == CH_CR || c == 8'h09 ||
             c == 8'h28 || c == 8'h29 || c == 8'h7B || c == 8'h7D ||
             c == 8'h5B || c == 8'h5D || c == 8'h3D || c == 8'h2C ||
             c == 8'h3B || c == CH_STAR || c == 8'h26 ||
             (c >= 8'h30 && c <= 8'h39);
   endfunction

   function automatic glob_type lex_global(input logic [7:0] c);
      glob_type g;
      g.mid      = ESC_NONE;
      g.has_byte = 1'b1;
      g.err      = 1'b0;
      g.mode     = MODE_GLOBAL;
      if (c == CH_SLASH) begin
         g.has_byte = 1'b0;
         g.mode     = MODE_SLASH;
      end else if (c == CH_QUOTE) begin
         g.mid  = ESC_STRING;
         g.mode = MODE_STRING;
      end else if (is_letter(c)) begin
         g.mid  = ESC_IDENT;
         g.mode = MODE_IDENT;
      end else if (!is_plain(c)) begin
         g.err = 1'b1;
      end
      return g;
   endfunction

   logic [7:0] c;
   glob_type   glob;

   assign c            = req_chan.text_byte;
   assign glob         = lex_global(c);
   assign req_chan.ready = !q_status.full;
   assign push         = req_chan.valid && req_chan.ready;

   always_comb begin
      push_cmd.pre      = ESC_NONE;
      push_cmd.lead     = 1'b0;
      push_cmd.mid      = ESC_NONE;
      push_cmd.has_byte = 1'b1;
      push_cmd.data     = c;
      push_cmd.err      = 1'b0;
      push_cmd.post     = 1'b0;
      push_cmd.trail    = 1'b0;
      mode_in           = mode_ff;

      unique case (mode_ff)
         MODE_SLASH: begin
            push_cmd.lead = 1'b1;
            if (c == CH_STAR) begin
               push_cmd.pre = ESC_BLOCK;
               mode_in      = MODE_BLOCK;
            end else if (c == CH_SLASH) begin
               push_cmd.pre = ESC_INLINE;
               mode_in      = MODE_INLINE;
            end else begin
               push_cmd.mid      = glob.mid;
               push_cmd.has_byte = glob.has_byte;
               push_cmd.err      = glob.err;
               mode_in           = glob.mode;
            end
         end
         MODE_IDENT: begin
            if (!is_letter(c)) begin
               push_cmd.pre      = ESC_OFF;
               push_cmd.mid      = glob.mid;
               push_cmd.has_byte = glob.has_byte;
               push_cmd.err      = glob.err;
               mode_in           = glob.mode;
            end
         end
         MODE_BLOCK: begin
            if (c == CH_STAR) begin
               mode_in = MODE_BLOCK_STAR;
            end
         end
         MODE_BLOCK_STAR: begin
            if (c == CH_SLASH) begin
               push_cmd.post = 1'b1;
               mode_in       = MODE_GLOBAL;
            end else if (c != CH_STAR) begin
               mode_in = MODE_BLOCK;
            end
         end
         MODE_INLINE: begin
            if (c == CH_LF || c == CH_CR) begin
               push_cmd.pre = ESC_OFF;
               mode_in      = MODE_GLOBAL;
            end
         end
         MODE_STRING: begin
            if (c == CH_BSLASH) begin
               mode_in = MODE_STRING_ESC;
            end else if (c == CH_QUOTE) begin
               push_cmd.post = 1'b1;
               mode_in       = MODE_GLOBAL;
            end
         end
         MODE_STRING_ESC: begin
            mode_in = MODE_STRING;
         end
         MODE_GLOBAL: begin
            push_cmd.mid      = glob.mid;
            push_cmd.has_byte = glob.has_byte;
            push_cmd.err      = glob.err;
            mode_in           = glob.mode;
         end
      endcase

      // end of text: flush held slash or close open color
      if (req_chan.end_of_text) begin
         if (mode_in == MODE_SLASH) begin
            push_cmd.trail = 1'b1;
         end else if (mode_in != MODE_GLOBAL) begin
            push_cmd.post = 1'b1;
         end
         mode_in = MODE_GLOBAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_GLOBAL;
      end else if (push) begin
         mode_ff <= mode_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/cshl_queue.sv
// -----------------------------------------------------------------------------
// C syntax highlight lexer plan queue
// Short FIFO of output plans between the front end and the emitter.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cshl_queue
   import cshl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  cmd_type      push_cmd,
   input  wire logic    pop,
   output cmd_type      head_cmd,
   output q_status_type q_status
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   assign q_status.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign q_status.empty = count_ff == '0;
   assign head_cmd       = entry_ff[rd_ptr_ff];
   assign do_pop         = pop && !q_status.empty;

   always_comb begin
      wr_ptr_in = push   ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (!push && do_pop) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### rtl/core/cshl_back.sv
// -----------------------------------------------------------------------------
// C syntax highlight lexer emitter
// Walks each queued plan and sends its bytes, one per cycle while the receiver is ready.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cshl_back
   import cshl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  cmd_type      head_cmd,
   input  q_status_type q_status,
   output logic         pop,
   cshl_rsp_if.source   rsp_chan
);

   localparam logic [2:0] SEG_PRE   = 3'd0;
   localparam logic [2:0] SEG_LEAD  = 3'd1;
   localparam logic [2:0] SEG_MID   = 3'd2;
   localparam logic [2:0] SEG_BYTE  = 3'd3;
   localparam logic [2:0] SEG_POST  = 3'd4;
   localparam logic [2:0] SEG_TRAIL = 3'd5;
   localparam int         NUM_SEG   = 6;

   typedef struct packed {
      logic       found;
      logic [2:0] seg;
   } seg_sel_type;

   function automatic logic [NUM_SEG-1:0] seg_mask(input cmd_type cmd);
      return {cmd.trail, cmd.post, cmd.has_byte, cmd.mid != ESC_NONE, cmd.lead,
              cmd.pre != ESC_NONE};
   endfunction

   function automatic seg_sel_type first_seg(input logic [NUM_SEG-1:0] mask,
                                             input logic [2:0] from);
      seg_sel_type s;
      s.found = 1'b0;
      s.seg   = SEG_PRE;
      for (int i = NUM_SEG - 1; i >= 0; i--) begin
         if (mask[i] && 3'(i) >= from) begin
            s.found = 1'b1;
            s.seg   = 3'(i);
         end
      end
      return s;
   endfunction

   function automatic logic [2:0] seg_len(input cmd_type cmd, input logic [2:0] seg);
      logic [2:0] len;
      unique case (seg)
         SEG_PRE:  len = esc_len(cmd.pre);
         SEG_MID:  len = esc_len(cmd.mid);
         SEG_POST: len = esc_len(ESC_OFF);
         default:  len = 3'd1;
      endcase
      return len;
   endfunction

   logic        busy_ff, busy_in;
   cmd_type     cmd_ff, cmd_in;
   logic [2:0]  seg_ff, seg_in;
   logic [2:0]  pos_ff, pos_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        err_ff, err_in;
   logic        last_ff, last_in;

   logic        advance, emit, seg_end, finish, can_load;
   seg_sel_type nxt, fst;
   logic [7:0]  cur_byte;
   logic        cur_err;

   assign advance  = !valid_ff || rsp_chan.ready;
   assign emit     = busy_ff && advance;
   assign seg_end  = pos_ff == 3'(seg_len(cmd_ff, seg_ff) - 3'd1);
   assign nxt      = first_seg(seg_mask(cmd_ff), 3'(seg_ff + 3'd1));
   assign fst      = first_seg(seg_mask(head_cmd), SEG_PRE);
   assign finish   = emit && seg_end && !nxt.found;
   assign can_load = !busy_ff || finish;
   assign pop      = can_load && !q_status.empty;

   always_comb begin
      cur_err = 1'b0;
      unique case (seg_ff)
         SEG_PRE:   cur_byte = esc_byte(cmd_ff.pre, pos_ff);
         SEG_LEAD:  cur_byte = CH_SLASH;
         SEG_MID:   cur_byte = esc_byte(cmd_ff.mid, pos_ff);
         SEG_BYTE: begin
            cur_byte = cmd_ff.data;
            cur_err  = cmd_ff.err;
         end
         SEG_POST:  cur_byte = esc_byte(ESC_OFF, pos_ff);
         SEG_TRAIL: cur_byte = CH_SLASH;
         default:   cur_byte = CH_SLASH;
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      cmd_in   = cmd_ff;
      seg_in   = seg_ff;
      pos_in   = pos_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      err_in   = err_ff;
      last_in  = last_ff;

      if (emit) begin
         if (seg_end) begin
            if (nxt.found) begin
               seg_in = nxt.seg;
               pos_in = 3'd0;
            end else begin
               busy_in = 1'b0;
            end
         end else begin
            pos_in = 3'(pos_ff + 3'd1);
         end
      end

      // an item with no result bytes is dropped here
      if (pop) begin
         cmd_in  = head_cmd;
         busy_in = fst.found;
         seg_in  = fst.seg;
         pos_in  = 3'd0;
      end

      if (advance) begin
         valid_in = emit;
         byte_in  = cur_byte;
         err_in   = cur_err;
         last_in  = finish;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      seg_ff  <= seg_in;
      pos_ff  <= pos_in;
      byte_ff <= byte_in;
      err_ff  <= err_in;
      last_ff <= last_in;
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.out_byte    = byte_ff;
   assign rsp_chan.parse_error = err_ff;
   assign rsp_chan.last_of_run = last_ff;

endmodule

`default_nettype wire

### rtl/core/c_syntax_highlight_lexer.sv
// -----------------------------------------------------------------------------
// C syntax highlight lexer
// Colors C source text with terminal escape sequences, one byte at a time.
// -----------------------------------------------------------------------------
// Usage:
//   req_chan carries one text byte per item, with end_of_text on the final
//   byte. rsp_chan carries the highlighted stream: text bytes and escape
//   bytes, parse_error on unknown bytes and last_of_run on the final byte
//   caused by each input item. An item may cause no result byte at all.
//   The front end takes one item per cycle while its four-entry plan queue
//   has room. The emitter sends one result byte per cycle while the
//   receiver is ready; an item with no result bytes is dropped by it.
//   The first result byte of an item passes the queue entry, the emitter's
//   plan register and the output register before it shows on rsp_chan.
//   Plain text runs at one item a cycle while the receiver is ready.
//   Reset returns the lexer to global mode, empties the queue and drops
//   any result byte held in the output register.
//   A stalled receiver holds the output register; the queue then fills and
//   req_chan.ready drops until the emitter moves again.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "c_syntax_highlight_lexer_macros.svh"

module c_syntax_highlight_lexer
   import cshl_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   cshl_req_if.sink   req_chan,
   cshl_rsp_if.source rsp_chan
);

   logic         push;
   logic         pop;
   cmd_type      push_cmd;
   cmd_type      head_cmd;
   q_status_type q_status;

   cshl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .push     (push),
      .push_cmd (push_cmd)
   );

   cshl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   cshl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .q_status (q_status),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   // an unknown byte never has more result bytes after it
   `CSHL_ASSERT_IMPLIES(a_err_is_last, clock, reset,
      rsp_chan.valid && rsp_chan.parse_error, rsp_chan.last_of_run)
   `CSHL_ASSERT_NEXT(a_reset_clears_out, clock, reset, !rsp_chan.valid)
   `CSHL_ASSERT_IMPLIES(a_err_not_slash, clock, reset,
      rsp_chan.valid && rsp_chan.parse_error, rsp_chan.out_byte != CH_SLASH)

endmodule

`default_nettype wire
